// ----- rtl/nsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nsb_pkg
// shared types, codes and defaults of the strip button detector
// ---------------------------------------------------------------------------
package nsb_pkg;

  localparam int unsigned SAMPLE_BITS         = 10;
  localparam int unsigned WINDOW_LEN_DEF      = 8;
  localparam int unsigned MAX_TOUCHPOINTS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NOISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TOUCH   = 3'd4;

  // register reset values
  localparam logic [7:0]  HALF_WIDTH_RST = 8'd20;
  localparam logic [12:0] MAX_NOISE_RST  = 13'd40;
  localparam logic [9:0]  MIN_LEVEL_RST  = 10'd10;
  localparam logic [15:0] MAX_WAIT_RST   = 16'd100;
  localparam logic [4:0]  NUM_TOUCH_RST  = 5'd0;

  // commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result status
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0]             command;
    logic [SAMPLE_BITS-1:0] sample;
    logic [3:0]             entry_index;
    logic [SAMPLE_BITS-1:0] entry_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] button;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/nsb_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nsb_ring
// noise window ring: sample differences, one read and one write port
// ---------------------------------------------------------------------------
module nsb_ring #(
  parameter int unsigned WINDOW_LEN = nsb_pkg::WINDOW_LEN_DEF,
  parameter int unsigned WIN_AW     = $clog2(WINDOW_LEN)
) (
  input  wire logic                            clk,
  input  wire logic [WIN_AW-1:0]               rd_addr,
  output      logic [nsb_pkg::SAMPLE_BITS-1:0] rd_data,
  input  wire logic                            wr_en,
  input  wire logic [WIN_AW-1:0]               wr_addr,
  input  wire logic [nsb_pkg::SAMPLE_BITS-1:0] wr_data
);
  import nsb_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/nsb_tptab.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nsb_tptab
// touchpoint table memory with the open-interval match on its read port
// ---------------------------------------------------------------------------
module nsb_tptab #(
  parameter int unsigned MAX_TOUCHPOINTS = nsb_pkg::MAX_TOUCHPOINTS_DEF,
  parameter int unsigned TP_AW = (MAX_TOUCHPOINTS > 1) ? $clog2(MAX_TOUCHPOINTS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [TP_AW-1:0]                wr_addr,
  input  wire logic [nsb_pkg::SAMPLE_BITS-1:0] wr_data,
  input  wire logic [TP_AW-1:0]                rd_addr,
  input  wire logic [nsb_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [7:0]                      half_width,
  output      logic                            hit
);
  import nsb_pkg::*;

  localparam int unsigned CW = SAMPLE_BITS + 1;

  logic [SAMPLE_BITS-1:0] mem [MAX_TOUCHPOINTS];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [CW-1:0]          v_ext;
  logic [CW-1:0]          c_ext;
  logic [CW-1:0]          a_ext;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // center - area < v < center + area, rearranged to stay unsigned
  always_comb begin
    v_ext = {1'b0, sample};
    c_ext = {1'b0, rd_data};
    a_ext = CW'(half_width);
    hit   = ((v_ext + a_ext) > c_ext) && (v_ext < (c_ext + a_ext));
  end

endmodule
`default_nettype wire

// ----- rtl/noise_gated_strip_button_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// noise_gated_strip_button_detector
// strip scanner: moving noise sum over a ring, touchpoint search on two
// consecutive quiet pressed samples, timeout on tick count
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in       in   in_valid / in_stall   in_data  (command, sample, index, pos)
//  out      out  out_valid / out_stall out_data (status, button)
//  cfg      in   cfg_we                cfg_index, cfg_wdata
//
//  load, start and ignored beats: accept moves to the done state, which loads
//    the result register and returns to idle to take the next beat
//  tick: accept, then the window state (ring read/modify/write), then one
//    search state per touchpoint visited when a search runs (one table read
//    per entry), then the done state and back to idle
//  rst_n is synchronous; it resets the control, scan and configuration registers,
//    payload registers are not reset and table contents stay undefined until loaded
//  a result waits in the output register under out_stall while the next
//    beat is accepted and processed; that beat then holds in the done state
// ---------------------------------------------------------------------------
module noise_gated_strip_button_detector #(
  parameter int unsigned WINDOW_LEN      = nsb_pkg::WINDOW_LEN_DEF,
  parameter int unsigned MAX_TOUCHPOINTS = nsb_pkg::MAX_TOUCHPOINTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire nsb_pkg::in_item_t              in_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      nsb_pkg::out_item_t             out_data,
  input  wire logic                           cfg_we,
  input  wire logic [nsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nsb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nsb_pkg::*;

  localparam int unsigned WIN_AW = $clog2(WINDOW_LEN);
  localparam int unsigned TP_AW  = (MAX_TOUCHPOINTS > 1) ? $clog2(MAX_TOUCHPOINTS) : 1;
  localparam int unsigned CNT_W  = TP_AW + 1;
  localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * ((2 ** SAMPLE_BITS) - 1) + 1);
  localparam int unsigned CMP_W  = (SUM_W > 13) ? SUM_W : 13;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WIN  = 4'b0010,
    S_SRCH = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // configuration
  logic [7:0]  half_width_r;
  logic [12:0] max_noise_r;
  logic [9:0]  min_level_r;
  logic [15:0] max_wait_r;
  logic [4:0]  num_touch_r;

  // scan state
  state_t                 state_r, state_nxt;
  logic                   scanning_r, scanning_nxt;
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [WIN_AW-1:0]      pos_r, pos_nxt;
  logic                   full_r, full_nxt;
  logic [1:0]             qcnt_r, qcnt_nxt;
  logic [15:0]            elapsed_r, elapsed_nxt;

  // working registers of the beat in flight
  logic [SAMPLE_BITS-1:0] samp_r, samp_nxt;
  logic [SAMPLE_BITS-1:0] diff_r, diff_nxt;
  logic [TP_AW-1:0]       k_r, k_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  out_item_t              res_r, res_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // memory ports
  logic [SAMPLE_BITS-1:0] ring_rd_data;
  logic                   ring_wr_en;
  logic                   tab_wr_en;
  logic [TP_AW-1:0]       tab_rd_addr;
  logic                   tab_hit;

  // window arithmetic
  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] old_diff;
  logic                   qualify;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ring_wr_en  = (state_r == S_WIN);
  assign tab_wr_en   = in_acc && (in_data.command == CMD_LOAD)
                       && (int'(in_data.entry_index) < MAX_TOUCHPOINTS);
  // entry 0 is read ahead while the window is updated
  assign tab_rd_addr = (state_r == S_SRCH) ? TP_AW'(k_r + 1'b1) : '0;

  nsb_ring #(
    .WINDOW_LEN (WINDOW_LEN),
    .WIN_AW     (WIN_AW)
  ) u_ring (
    .clk     (clk),
    .rd_addr (pos_r),
    .rd_data (ring_rd_data),
    .wr_en   (ring_wr_en),
    .wr_addr (pos_r),
    .wr_data (diff_r)
  );

  nsb_tptab #(
    .MAX_TOUCHPOINTS (MAX_TOUCHPOINTS),
    .TP_AW           (TP_AW)
  ) u_tptab (
    .clk        (clk),
    .wr_en      (tab_wr_en),
    .wr_addr    (TP_AW'(in_data.entry_index)),
    .wr_data    (in_data.entry_position),
    .rd_addr    (tab_rd_addr),
    .sample     (samp_r),
    .half_width (half_width_r),
    .hit        (tab_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    scanning_nxt  = scanning_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    full_nxt      = full_r;
    qcnt_nxt      = qcnt_r;
    elapsed_nxt   = elapsed_r;
    samp_nxt      = samp_r;
    diff_nxt      = diff_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    // ring slots not written since the scan began read as zero
    old_diff      = full_r ? ring_rd_data : '0;
    qualify       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt   = '{status: ST_BUSY, button: 4'd0};
          state_nxt = S_DONE;
          if (in_data.command == CMD_START) begin
            scanning_nxt = 1'b1;
            prev_nxt     = '0;
            sum_nxt      = '0;
            pos_nxt      = '0;
            full_nxt     = 1'b0;
            qcnt_nxt     = '0;
            elapsed_nxt  = '0;
          end else if (in_data.command == CMD_TICK && scanning_r) begin
            // ring read of the slot at pos_r is issued this cycle
            samp_nxt  = in_data.sample;
            diff_nxt  = (in_data.sample > prev_r) ? (in_data.sample - prev_r)
                                                  : (prev_r - in_data.sample);
            prev_nxt  = in_data.sample;
            state_nxt = S_WIN;
          end
        end
      end

      S_WIN: begin
        sum_nxt = (sum_r - SUM_W'(old_diff)) + SUM_W'(diff_r);
        if (pos_r == WIN_AW'(WINDOW_LEN - 1)) begin
          pos_nxt  = '0;
          full_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
        if (elapsed_r != 16'hFFFF) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
        qualify = full_nxt && (CMP_W'(sum_nxt) < CMP_W'(max_noise_r))
                  && (samp_r > min_level_r);
        state_nxt = S_DONE;
        if (qualify) begin
          if (qcnt_r != 2'd2) begin
            qcnt_nxt = qcnt_r + 2'd1;
          end
        end else begin
          qcnt_nxt = '0;
        end
        if (qualify && qcnt_r == 2'd1) begin
          // second quiet pressed sample: search decides, timeout ignored
          scanning_nxt = 1'b0;
          if (int'(num_touch_r) > MAX_TOUCHPOINTS) begin
            n_nxt = CNT_W'(MAX_TOUCHPOINTS);
          end else begin
            n_nxt = CNT_W'(num_touch_r);
          end
          k_nxt = '0;
          if (n_nxt == '0) begin
            res_nxt.status = ST_OUTSIDE;
          end else begin
            state_nxt = S_SRCH;
          end
        end else if (elapsed_nxt >= max_wait_r) begin
          res_nxt.status = ST_TIMEOUT;
          scanning_nxt   = 1'b0;
        end
      end

      S_SRCH: begin
        // table data for entry k_r is valid this cycle
        if (tab_hit) begin
          res_nxt   = '{status: ST_FOUND, button: 4'(k_r)};
          state_nxt = S_DONE;
        end else if (CNT_W'(k_r) + 1'b1 == n_r) begin
          res_nxt.status = ST_OUTSIDE;
          state_nxt      = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scanning_r  <= 1'b0;
      prev_r      <= '0;
      sum_r       <= '0;
      pos_r       <= '0;
      full_r      <= 1'b0;
      qcnt_r      <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scanning_r  <= scanning_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      full_r      <= full_nxt;
      qcnt_r      <= qcnt_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    samp_r <= samp_nxt;
    diff_r <= diff_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
      max_noise_r  <= MAX_NOISE_RST;
      min_level_r  <= MIN_LEVEL_RST;
      max_wait_r   <= MAX_WAIT_RST;
      num_touch_r  <= NUM_TOUCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_WIDTH: half_width_r <= cfg_wdata[7:0];
        REG_MAX_NOISE:  max_noise_r  <= cfg_wdata[12:0];
        REG_MIN_LEVEL:  min_level_r  <= cfg_wdata[9:0];
        REG_MAX_WAIT:   max_wait_r   <= cfg_wdata[15:0];
        REG_NUM_TOUCH:  num_touch_r  <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // a new result only comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result register loaded outside done state");

  // button is zero unless a touchpoint matched
  a_button_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_FOUND) |-> (out_r.button == 4'd0))
    else $error("button set without a match");

  // search index never passes the entry count
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (CNT_W'(k_r) < n_r))
    else $error("search ran past the table");

  // a scan only ends while a tick is processed
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(scanning_r) |-> $past(state_r == S_WIN))
    else $error("scan ended outside tick processing");

endmodule
`default_nettype wire
